>>> sv/hpsd_pkg.sv
package hpsd_pkg;

  // configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TARGET = 2'd0,
    REG_PROP   = 2'd1,
    REG_DERIV  = 2'd2,
    REG_INTEG  = 2'd3
  } cfg_reg_t;

  // register reset values
  localparam logic signed [13:0] TARGET_RESET = -14'sd960;
  localparam logic [15:0]        PROP_RESET   = 16'd256;
  localparam logic [15:0]        DERIV_RESET  = 16'd256;
  localparam logic [15:0]        INTEG_RESET  = 16'd51;

  // tilt trip limits, 1/16 degree (z limits include the 90 degree offset)
  localparam logic signed [12:0] TILT_HI   = 13'sd720;
  localparam logic signed [12:0] TILT_LO   = -13'sd720;
  localparam logic signed [12:0] Z_TRIP_HI = 13'sd2160;
  localparam logic signed [12:0] Z_TRIP_LO = 13'sd720;

  // heading error handling
  localparam logic signed [15:0] WRAP_ABOVE = 16'sd2880;
  localparam logic signed [15:0] FULL_TURN  = 16'sd5760;
  localparam logic signed [15:0] ERR_LIMIT  = 16'sd960;
  localparam logic signed [10:0] ERR_HI     = 11'sd960;
  localparam logic signed [10:0] ERR_LO     = -11'sd960;

  // integrator limits
  localparam logic signed [47:0] ACC_CAP     = 48'sh4000_0000_0000;
  localparam logic signed [47:0] ACC_CAP_NEG = -48'sh4000_0000_0000;
  localparam logic signed [49:0] ACC_MAX     = 50'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [49:0] ACC_MIN     = -50'sh0_8000_0000_0000;

  // output scaling
  localparam logic signed [10:0] MS_PER_S    = 11'sd1000;
  localparam logic [16:0]        Q_CLIP      = 17'd100000;
  localparam logic [17:0]        RECIP_1000  = 18'd134218;
  localparam int                 RECIP_1000_SH = 27;
  localparam logic [10:0]        RECIP_10    = 11'd1639;
  localparam int                 RECIP_10_SH = 14;
  localparam logic [7:0]         OUT_LIMIT   = 8'd100;
  localparam logic [7:0]         CENTER      = 8'd90;
  localparam logic [6:0]         CENTER_L    = 7'd90;

  // products handed from the front stage to the scaling pipeline
  typedef struct packed {
    logic signed [27:0] kp_e;
    logic signed [33:0] kd_d;
    logic [39:0]        ki_lo;
    logic signed [40:0] ki_hi;
    logic               trip;
  } hpsd_prod_t;

endpackage

>>> sv/hpsd_if.sv
interface hpsd_in_if;
  logic               valid;
  logic               ready;
  logic [12:0]        heading;
  logic signed [12:0] tilt_y;
  logic signed [12:0] tilt_z_raw;
  logic signed [15:0] rate_y;
  logic [31:0]        now_ms;

  modport source (output valid, heading, tilt_y, tilt_z_raw, rate_y, now_ms, input ready);
  modport sink   (input valid, heading, tilt_y, tilt_z_raw, rate_y, now_ms, output ready);
endinterface

interface hpsd_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] left_servo;
  logic [7:0] right_servo;
  logic       tilt_tripped;

  modport source (output valid, left_servo, right_servo, tilt_tripped, input ready);
  modport sink   (input valid, left_servo, right_servo, tilt_tripped, output ready);
endinterface

>>> sv/hpsd_front.sv
module hpsd_front import hpsd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_wdata,
  hpsd_in_if.sink             sample,
  input  logic                back_take,
  output logic                prod_valid,
  output hpsd_prod_t          prod
);

  logic signed [13:0] target;
  logic [15:0]        kp;
  logic [15:0]        kd;
  logic [15:0]        ki;

  logic               s1_valid;
  logic [12:0]        s1_heading;
  logic signed [12:0] s1_tilt_y;
  logic signed [12:0] s1_tilt_z;
  logic signed [15:0] s1_rate;
  logic [31:0]        s1_now;

  logic signed [47:0] integral_acc;
  logic [31:0]        prev_time;

  logic               en1;
  logic               en2;
  logic               trip;
  logic signed [15:0] err_raw;
  logic signed [15:0] err;
  logic signed [10:0] err_c;
  logic [31:0]        dt;
  logic signed [16:0] deriv;
  logic signed [47:0] acc_c;
  logic signed [48:0] step;
  logic signed [49:0] acc_sum;
  logic signed [47:0] integral_acc_next;
  hpsd_prod_t         prod_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target <= TARGET_RESET;
      kp     <= PROP_RESET;
      kd     <= DERIV_RESET;
      ki     <= INTEG_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_TARGET: target <= cfg_wdata[13:0];
        REG_PROP:   kp     <= cfg_wdata;
        REG_DERIV:  kd     <= cfg_wdata;
        REG_INTEG:  ki     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage enables, a stage moves when empty or when its successor moves
  assign en2          = !prod_valid || back_take;
  assign en1          = !s1_valid || en2;
  assign sample.ready = en1;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en1) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && sample.valid) begin
      s1_heading <= sample.heading;
      s1_tilt_y  <= sample.tilt_y;
      s1_tilt_z  <= sample.tilt_z_raw;
      s1_rate    <= sample.rate_y;
      s1_now     <= sample.now_ms;
    end
  end

  // tilt check, heading error, elapsed time
  always_comb begin
    trip = (s1_tilt_y > TILT_HI) || (s1_tilt_y < TILT_LO) ||
           (s1_tilt_z > Z_TRIP_HI) || (s1_tilt_z < Z_TRIP_LO);

    err_raw = $signed({3'b000, s1_heading}) - 16'(target);
    err     = (err_raw > WRAP_ABOVE) ? err_raw - FULL_TURN : err_raw;

    if (err > ERR_LIMIT) begin
      err_c = ERR_HI;
    end else if (err < -ERR_LIMIT) begin
      err_c = ERR_LO;
    end else begin
      err_c = err[10:0];
    end

    dt    = s1_now - prev_time;
    deriv = (dt != '0) ? -17'(s1_rate) : '0;
  end

  // integrator: capped copy for the gain product, saturating update
  always_comb begin
    if (integral_acc > ACC_CAP) begin
      acc_c = ACC_CAP;
    end else if (integral_acc < ACC_CAP_NEG) begin
      acc_c = ACC_CAP_NEG;
    end else begin
      acc_c = integral_acc;
    end

    step    = 49'(err) * 49'($signed({1'b0, dt}));
    acc_sum = 50'(integral_acc) + 50'(step);

    if (acc_sum > ACC_MAX) begin
      integral_acc_next = ACC_MAX[47:0];
    end else if (acc_sum < ACC_MIN) begin
      integral_acc_next = ACC_MIN[47:0];
    end else begin
      integral_acc_next = acc_sum[47:0];
    end
  end

  // controller state, untouched on a tilt trip
  always_ff @(posedge clk) begin
    if (rst) begin
      integral_acc <= '0;
      prev_time    <= '0;
    end else if (s1_valid && en2 && !trip) begin
      integral_acc <= integral_acc_next;
      prev_time    <= s1_now;
    end
  end

  // gain products, integral product split in two halves
  always_comb begin
    prod_next.kp_e  = 28'($signed({1'b0, kp})) * 28'(err_c);
    prod_next.kd_d  = 34'($signed({1'b0, kd})) * 34'(deriv);
    prod_next.ki_lo = 40'(ki) * 40'(acc_c[23:0]);
    prod_next.ki_hi = 41'($signed({1'b0, ki})) * 41'($signed(acc_c[47:24]));
    prod_next.trip  = trip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (en2) begin
      prod_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      prod <= prod_next;
    end
  end

endmodule

>>> sv/hpsd_back.sv
module hpsd_back import hpsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       prod_valid,
  input  hpsd_prod_t prod,
  output logic       back_take,
  hpsd_out_if.source drive
);

  logic               s3_valid;
  logic signed [44:0] s3_pd1000;
  logic signed [63:0] s3_kacc;
  logic               s3_trip;

  logic               s4_valid;
  logic [16:0]        s4_q;
  logic               s4_neg;
  logic               s4_trip;

  logic               s5_valid;
  logic [7:0]         s5_v;
  logic               s5_trip;

  logic               en3;
  logic               en4;
  logic               en5;
  logic               en_o;

  logic signed [34:0] pd;
  logic signed [44:0] pd1000;
  logic signed [63:0] kacc;
  logic signed [63:0] sum;
  logic [63:0]        mag;
  logic [51:0]        q;
  logic [16:0]        q_c;
  logic [34:0]        q_scaled;
  logic [7:0]         deg_mag;
  logic [7:0]         v;
  logic [10:0]        x9;
  logic [21:0]        x_scaled;
  logic [7:0]         servo;
  logic [6:0]         left_next;
  logic [7:0]         right_next;

  // stage enables
  assign en_o      = !drive.valid || drive.ready;
  assign en5       = !s5_valid || en_o;
  assign en4       = !s4_valid || en5;
  assign en3       = !s3_valid || en4;
  assign back_take = en3;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid    <= 1'b0;
      s4_valid    <= 1'b0;
      s5_valid    <= 1'b0;
      drive.valid <= 1'b0;
    end else begin
      if (en3)  s3_valid    <= prod_valid;
      if (en4)  s4_valid    <= s3_valid;
      if (en5)  s5_valid    <= s4_valid;
      if (en_o) drive.valid <= s5_valid;
    end
  end

  // pd term scaled to ms, integral product reassembled
  always_comb begin
    pd     = 35'($signed(prod.kp_e)) + 35'($signed(prod.kd_d));
    pd1000 = 45'(pd) * 45'(MS_PER_S);
    kacc   = (64'($signed(prod.ki_hi)) <<< 24) + $signed({24'b0, prod.ki_lo});
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_pd1000 <= pd1000;
      s3_kacc   <= kacc;
      s3_trip   <= prod.trip;
    end
  end

  // full sum, magnitude over 4096, clipped where the output saturates
  always_comb begin
    sum = 64'(s3_pd1000) + s3_kacc;
    mag = sum[63] ? 64'(-sum) : 64'(sum);
    q   = mag[63:12];
    q_c = (q >= 52'(Q_CLIP)) ? Q_CLIP : q[16:0];
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_q    <= q_c;
      s4_neg  <= sum[63];
      s4_trip <= s3_trip;
    end
  end

  // divide by 1000 with a reciprocal, then offset into 0..200
  always_comb begin
    q_scaled = 35'(s4_q) * 35'(RECIP_1000);
    deg_mag  = q_scaled[RECIP_1000_SH +: 8];
    v        = s4_neg ? OUT_LIMIT - deg_mag : OUT_LIMIT + deg_mag;
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_v    <= v;
      s5_trip <= s4_trip;
    end
  end

  // map to 0..180 as v*9/10, split into left and right commands
  always_comb begin
    x9         = 11'({s5_v, 3'b000}) + 11'(s5_v);
    x_scaled   = 22'(x9) * 22'(RECIP_10);
    servo      = x_scaled[RECIP_10_SH +: 8];
    left_next  = (servo > CENTER) ? CENTER_L : servo[6:0];
    right_next = (servo < CENTER) ? CENTER : servo;
  end

  // output register, centered on a tilt trip
  always_ff @(posedge clk) begin
    if (en_o) begin
      if (s5_trip) begin
        drive.left_servo  <= CENTER_L;
        drive.right_servo <= CENTER;
      end else begin
        drive.left_servo  <= left_next;
        drive.right_servo <= right_next;
      end
      drive.tilt_tripped <= s5_trip;
    end
  end

endmodule

>>> sv/heading_pid_servo_drive.sv
// path: a sample passes the input, product, s3, s4, s5 and output registers
// throughput: one sample per cycle unless stalled; integrator and time stamp
//   update in the input stage, so each sees the state left by the sample before
// stalls: each stage moves when its successor is empty or moving
// reset: synchronous rst empties the pipeline, zeroes the integrator and the
//   time stamp, and loads the gain and target registers with their defaults
module heading_pid_servo_drive import hpsd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_wdata,
  hpsd_in_if.sink             sample,
  hpsd_out_if.source          drive
);

  logic       prod_valid;
  logic       back_take;
  hpsd_prod_t prod;

  // error, state update and gain products
  hpsd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .sample     (sample),
    .back_take  (back_take),
    .prod_valid (prod_valid),
    .prod       (prod)
  );

  // scaling, limiting and servo mapping
  hpsd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .prod_valid (prod_valid),
    .prod       (prod),
    .back_take  (back_take),
    .drive      (drive)
  );

endmodule

>>> sv/hpsd_checker.sv
module hpsd_checker import hpsd_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] left_servo,
  input logic [7:0] right_servo,
  input logic       tilt_tripped
);

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_servo) &&
      $stable(right_servo) && $stable(tilt_tripped))
    else $error("stalled result changed");

  // an open output never blocks the input
  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output is open");

  // a tilt trip centers both servos
  a_trip_center: assert property (@(posedge clk) disable iff (rst)
    out_valid && tilt_tripped |-> left_servo == CENTER_L && right_servo == CENTER)
    else $error("tripped result not centered");

  // one side always sits at center, the other within its range
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (left_servo == CENTER_L || right_servo == CENTER) &&
      right_servo <= 8'd180)
    else $error("servo commands out of range");

endmodule

bind heading_pid_servo_drive hpsd_checker u_hpsd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (sample.ready),
  .out_valid    (drive.valid),
  .out_ready    (drive.ready),
  .left_servo   (drive.left_servo),
  .right_servo  (drive.right_servo),
  .tilt_tripped (drive.tilt_tripped)
);
